FILE: sv/tcfir_pkg.sv
// shared constants and word types for the three channel fir filter
package tcfir_pkg;

   localparam int TAPS     = 4096;
   localparam int NCHAN    = 3;
   localparam int CH_W     = 2;
   localparam int SAMPLE_W = 24;
   localparam int COEF_W   = 32;
   localparam int IDX_W    = 12;
   localparam int OUT_W    = 32;
   localparam int FRAC     = 30;

   // tap address and delay memory geometry
   localparam int TAP_AW   = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int DL_DEPTH = NCHAN * TAPS;
   localparam int DL_AW    = $clog2(DL_DEPTH);

   // datapath widths
   localparam int PROD_W   = SAMPLE_W + 1 + COEF_W;
   localparam int ACC_W    = PROD_W + TAP_AW + 1;
   localparam int Q_W      = ACC_W - FRAC;

   // operation codes
   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_COEF   = 1'b1;

   typedef struct packed {
      logic                     op;
      logic [CH_W-1:0]          chan;
      logic [SAMPLE_W-1:0]      sample;
      logic [IDX_W-1:0]         coef_index;
      logic signed [COEF_W-1:0] coef_value;
   } req_word_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] filtered;
      logic [CH_W-1:0]         out_chan;
   } rsp_word_type;

endpackage

FILE: sv/three_channel_fir_filter.sv
// three channel direct form fir filter with one shared coefficient table
// each sample word occupies the filter until its result is written to the output register,
//   as the single multiply-accumulate steps once per tap through the delay and coefficient
//   memories; no new word is taken before then
// coefficient words are taken one per cycle while the filter is idle
// reset: a clearing pass zeroes both memories, req_ready low
module three_channel_fir_filter import tcfir_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   // one-hot sequencer states
   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_RUN   = 6'b000100,
      S_DRAIN = 6'b001000,
      S_ROUND = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // control registers
   logic [DL_AW-1:0]  clr_ff, clr_in;
   logic [TAP_AW-1:0] ptr_ff [NCHAN];
   logic [TAP_AW-1:0] tap_ff, tap_in;
   logic              rd_v_ff, rd_v_in;
   logic              mul_v_ff, mul_v_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [CH_W-1:0]         ch_ff, ch_in;
   logic [TAP_AW-1:0]       pos_ff, pos_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [Q_W-1:0]    q_ff, q_in;
   rsp_word_type            rsp_ff, rsp_in;

   // memory ports
   logic                dl_wr_en;
   logic [DL_AW-1:0]    dl_wr_addr;
   logic [SAMPLE_W-1:0] dl_wr_data;
   logic [DL_AW-1:0]    dl_rd_addr;
   logic [SAMPLE_W-1:0] dl_rd_data;
   logic                cf_wr_en;
   logic [TAP_AW-1:0]   cf_wr_addr;
   logic [COEF_W-1:0]   cf_wr_data;
   logic [COEF_W-1:0]   cf_rd_data;

   // decoded handshakes
   logic              req_fire;
   logic              filt_fire;
   logic              coef_fire;
   logic [TAP_AW-1:0] cur_ptr;
   logic signed [ACC_W-1:0] bias;
   logic signed [OUT_W-1:0] sat_val;

   // start of a channel's delay line in the shared memory
   function automatic logic [DL_AW-1:0] chan_base(input logic [CH_W-1:0] ch);
      chan_base = DL_AW'(ch) * DL_AW'(TAPS);
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign filt_fire = req_fire && (req_word.op == OP_FILTER)
                      && (req_word.chan < CH_W'(NCHAN));
   assign coef_fire = req_fire && (req_word.op == OP_COEF)
                      && ({1'b0, req_word.coef_index} < (IDX_W + 1)'(TAPS));
   assign cur_ptr   = ptr_ff[req_word.chan];

   // delay memory: zeroed by the clearing pass, new sample lands at the write pointer
   always_comb begin
      if (state_ff == S_CLEAR) begin
         dl_wr_en   = 1'b1;
         dl_wr_addr = clr_ff;
         dl_wr_data = '0;
      end else begin
         dl_wr_en   = filt_fire;
         dl_wr_addr = chan_base(req_word.chan) + DL_AW'(cur_ptr);
         dl_wr_data = req_word.sample;
      end
   end

   // coefficient memory: zeroed alongside the delay memory, then loaded by coefficient words
   always_comb begin
      if (state_ff == S_CLEAR) begin
         cf_wr_en   = ({1'b0, clr_ff} < (DL_AW + 1)'(TAPS));
         cf_wr_addr = clr_ff[TAP_AW-1:0];
         cf_wr_data = '0;
      end else begin
         cf_wr_en   = coef_fire;
         cf_wr_addr = req_word.coef_index[TAP_AW-1:0];
         cf_wr_data = req_word.coef_value;
      end
   end

   // newest sample sits at the pointer, older ones follow upward with wrap
   assign dl_rd_addr = chan_base(ch_ff) + DL_AW'(pos_ff);

   tcfir_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DL_DEPTH)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (dl_wr_en),
      .wr_addr (dl_wr_addr),
      .wr_data (dl_wr_data),
      .rd_addr (dl_rd_addr),
      .rd_data (dl_rd_data)
   );

   tcfir_ram #(
      .WIDTH (COEF_W),
      .DEPTH (TAPS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (cf_wr_en),
      .wr_addr (cf_wr_addr),
      .wr_data (cf_wr_data),
      .rd_addr (tap_ff),
      .rd_data (cf_rd_data)
   );

   // truncation toward zero: bias negative sums before the arithmetic shift
   assign bias = acc_ff[ACC_W-1] ? ACC_W'((64'd1 << FRAC) - 64'd1) : '0;

   // saturate the shifted sum to the 32 bit signed range
   always_comb begin
      if (q_ff > Q_W'(signed'({1'b0, {(OUT_W-1){1'b1}}}))) begin
         sat_val = {1'b0, {(OUT_W-1){1'b1}}};
      end else if (q_ff < Q_W'(signed'({1'b1, {(OUT_W-1){1'b0}}}))) begin
         sat_val = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         sat_val = q_ff[OUT_W-1:0];
      end
   end

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      tap_in       = tap_ff;
      ch_in        = ch_ff;
      pos_in       = pos_ff;
      rd_v_in      = 1'b0;
      mul_v_in     = rd_v_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      // exact product of the unsigned sample and the signed coefficient
      prod_in      = $signed({1'b0, dl_rd_data}) * $signed(cf_rd_data);
      acc_in       = mul_v_ff ? acc_ff + ACC_W'(prod_ff) : acc_ff;
      q_in         = q_ff;

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + DL_AW'(1);
            if (clr_ff == DL_AW'(DL_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (filt_fire) begin
               ch_in    = req_word.chan;
               pos_in   = cur_ptr;
               tap_in   = '0;
               acc_in   = '0;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            // issue one tap read per cycle
            rd_v_in = 1'b1;
            tap_in  = tap_ff + TAP_AW'(1);
            pos_in  = (pos_ff == TAP_AW'(TAPS - 1)) ? '0 : pos_ff + TAP_AW'(1);
            if (tap_ff == TAP_AW'(TAPS - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // wait for the read and multiply stages to empty into the sum
            if (!rd_v_ff && !mul_v_ff) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            q_in     = Q_W'((acc_ff + bias) >>> FRAC);
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.filtered   = sat_val;
               rsp_in.out_chan   = ch_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         tap_ff       <= '0;
         rd_v_ff      <= 1'b0;
         mul_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NCHAN; c++) begin
            ptr_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         tap_ff       <= tap_in;
         rd_v_ff      <= rd_v_in;
         mul_v_ff     <= mul_v_in;
         rsp_valid_ff <= rsp_valid_in;
         // pointer steps down with wrap once its sample is stored
         if (filt_fire) begin
            ptr_ff[req_word.chan] <= (cur_ptr == '0) ? TAP_AW'(TAPS - 1)
                                                     : cur_ptr - TAP_AW'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ch_ff   <= ch_in;
      pos_ff  <= pos_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      q_ff    <= q_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

FILE: sv/tcfir_ram.sv
// generic single write port ram with registered read
module tcfir_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/tcfir_check.sv
// port level checks for the three channel fir filter, bound to the top level
module tcfir_check import tcfir_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_word
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // a filtered sample occupies the filter, no new word right after it
   a_busy_after_sample: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_word.op == OP_FILTER)
      && (req_word.chan < CH_W'(NCHAN)) |=> !req_ready)
      else $error("word accepted while filter busy");

   // a coefficient word leaves the filter idle
   a_coef_keeps_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_word.op == OP_COEF) |=> req_ready)
      else $error("coefficient word stalled the input");

   // a new result only appears at the end of a filter run
   a_rsp_from_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a filter run");

endmodule

bind three_channel_fir_filter tcfir_check u_tcfir_check (.*);
